>>> rtl/core/vse_pkg.sv
`timescale 1ns / 1ps
// Voxel span expander: shared types, constants and register indexes.
// No dependencies; used by every module of the block.
package vse_pkg;

  // Section size limit and the derived byte offset saturation point
  localparam int unsigned MAX_SECTION_BYTES = 1048576;
  localparam int unsigned OFS_W = 20;
  localparam int unsigned HPOS_W = 10;
  localparam int unsigned OFS_SPAN =
      (MAX_SECTION_BYTES < (1 << OFS_W)) ? MAX_SECTION_BYTES : (1 << OFS_W);
  localparam logic [OFS_W-1:0] OFS_LIMIT = OFS_W'(OFS_SPAN - 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TOTAL = 2'd1;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // Parser phase within a span
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_COLOR  = 4'b0100,
    PH_NORMAL = 4'b1000
  } phase_e;

  // One output transaction
  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic             column_empty;
    logic [OFS_W-1:0] span_first;
    logic [OFS_W-1:0] span_final;
    logic             section_done;
    logic             overflow;
    logic             run_last;
  } result_t;

  // All results caused by one input byte, in output order
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     item;
  } result_batch_t;

endpackage

>>> rtl/core/vse_core.sv
`timescale 1ns / 1ps
// Span parser: configuration registers, column/section state and result
// generation for one input byte per cycle while accept_i is high. Depends on vse_pkg.
module vse_core import vse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  output result_batch_t        batch_o
);

  // Saturating offset step: returns {overflow, offset}
  function automatic logic [OFS_W:0] sat_inc(input logic [OFS_W-1:0] ofs,
                                             input logic ovf);
    logic [OFS_W:0] r;
    if (ofs >= OFS_LIMIT) begin
      r = {1'b1, OFS_LIMIT};
    end else begin
      r = {ovf, ofs + OFS_W'(1)};
    end
    return r;
  endfunction

  logic [7:0]        height_cfg_q;
  logic [15:0]       total_cfg_q;

  phase_e            phase_q, phase_d;
  logic [HPOS_W-1:0] hpos_q, hpos_d;
  logic [7:0]        pairs_q, pairs_d;
  logic [7:0]        span_q, span_d;
  logic [OFS_W-1:0]  ofs_q, ofs_d;
  logic [OFS_W-1:0]  col_start_q, col_start_d;
  logic [15:0]       cols_q, cols_d;
  logic              ovf_q, ovf_d;
  logic              has_q, has_d;

  logic              data1_en, fin, end_skip, fin_end, end_col, done;
  logic [7:0]        fin_byte;
  logic [HPOS_W-1:0] hpos_new;
  logic [7:0]        pairs_new;
  phase_e            phase_new;
  logic [OFS_W-1:0]  ofs1, ofs_e;
  logic              ovf1, ovf_e, has_e;
  logic [OFS_W:0]    step1, step2;
  logic [15:0]       cols_inc;
  result_t           res_d1, res_d2, res_rec;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_cfg_q <= 8'd1;
      total_cfg_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLUMN_HEIGHT: height_cfg_q <= cfg_wdata_i[7:0];
        CFG_COLUMN_TOTAL:  total_cfg_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Span decode for the incoming byte
  always_comb begin
    data1_en  = 1'b0;
    fin       = 1'b0;
    end_skip  = 1'b0;
    fin_byte  = span_q;
    hpos_new  = hpos_q;
    pairs_new = pairs_q;
    span_d    = span_q;
    phase_new = phase_q;
    case (phase_q)
      PH_SKIP: begin
        if (in_byte_i == height_cfg_q) begin
          end_skip = 1'b1;
        end else begin
          data1_en  = 1'b1;
          hpos_new  = hpos_q + HPOS_W'(in_byte_i);
          phase_new = PH_COUNT;
        end
      end
      PH_COUNT: begin
        data1_en  = 1'b1;
        span_d    = in_byte_i;
        pairs_new = in_byte_i;
        fin_byte  = in_byte_i;
        fin       = (in_byte_i == 8'd0);
        phase_new = PH_COLOR;
      end
      PH_COLOR: begin
        data1_en  = 1'b1;
        phase_new = PH_NORMAL;
      end
      PH_NORMAL: begin
        data1_en  = 1'b1;
        pairs_new = pairs_q - 8'd1;
        hpos_new  = hpos_q + HPOS_W'(1);
        fin       = (pairs_new == 8'd0);
        phase_new = PH_COLOR;
      end
      default: ;
    endcase
    if (fin) begin
      phase_new = PH_SKIP;
    end
    fin_end = fin && (hpos_new >= {2'b00, height_cfg_q});
    end_col = end_skip || fin_end;
  end

  // Offset accounting for up to two data bytes
  always_comb begin
    step1 = sat_inc(ofs_q, ovf_q);
    {ovf1, ofs1} = data1_en ? step1 : {ovf_q, ofs_q};
    step2 = sat_inc(ofs1, ovf1);
    {ovf_e, ofs_e} = fin ? step2 : {ovf1, ofs1};
    has_e    = has_q | data1_en;
    cols_inc = cols_q + 16'd1;
    done     = (cols_inc == total_cfg_q);
  end

  // Result assembly
  always_comb begin
    res_d1              = '0;
    res_d1.kind         = KIND_DATA;
    res_d1.data_byte    = in_byte_i;
    res_d1.overflow     = ovf1;
    res_d1.run_last     = !fin;

    res_d2              = '0;
    res_d2.kind         = KIND_DATA;
    res_d2.data_byte    = fin_byte;
    res_d2.overflow     = step2[OFS_W];
    res_d2.run_last     = !fin_end;

    res_rec              = '0;
    res_rec.kind         = KIND_RECORD;
    res_rec.column_empty = !has_e;
    res_rec.span_first   = has_e ? col_start_q : '0;
    res_rec.span_final   = !has_e ? '0 : (ovf_e ? OFS_LIMIT : ofs_e - OFS_W'(1));
    res_rec.section_done = done;
    res_rec.overflow     = ovf_e;
    res_rec.run_last     = 1'b1;

    batch_o.item[0] = data1_en ? res_d1 : res_rec;
    batch_o.item[1] = res_d2;
    batch_o.item[2] = res_rec;
    if (end_skip) begin
      batch_o.count = 2'd1;
    end else begin
      batch_o.count = 2'd1 + 2'(fin) + 2'(fin_end);
    end
  end

  // Next state
  always_comb begin
    phase_d     = phase_new;
    hpos_d      = hpos_new;
    pairs_d     = pairs_new;
    ofs_d       = ofs_e;
    ovf_d       = ovf_e;
    has_d       = has_e;
    cols_d      = cols_q;
    col_start_d = col_start_q;
    if (end_col) begin
      phase_d = PH_SKIP;
      hpos_d  = '0;
      pairs_d = '0;
      has_d   = 1'b0;
      if (done) begin
        ofs_d  = '0;
        ovf_d  = 1'b0;
        cols_d = '0;
      end else begin
        cols_d = cols_inc;
      end
      col_start_d = done ? '0 : ofs_e;
    end
  end

  // State registers, advanced once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      hpos_q      <= '0;
      pairs_q     <= '0;
      span_q      <= '0;
      ofs_q       <= '0;
      col_start_q <= '0;
      cols_q      <= '0;
      ovf_q       <= 1'b0;
      has_q       <= 1'b0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      hpos_q      <= hpos_d;
      pairs_q     <= pairs_d;
      span_q      <= span_d;
      ofs_q       <= ofs_d;
      col_start_q <= col_start_d;
      cols_q      <= cols_d;
      ovf_q       <= ovf_d;
      has_q       <= has_d;
    end
  end

  // Overflow flag only ever stands with the offset pinned at its limit
  a_ovf_pinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (ofs_q == OFS_LIMIT))
    else $error("overflow flag set with offset below limit");

  // Section end restarts offsets, the overflow flag and the column count
  a_section_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_col && done) |=> (ofs_q == '0) && !ovf_q && (cols_q == '0))
    else $error("section end did not restart offsets");

  // A column in progress never starts past the current offset
  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_start_q <= ofs_q)
    else $error("column start beyond byte offset");

endmodule

>>> rtl/core/vse_outq.sv
`timescale 1ns / 1ps
// Four-entry result queue: takes up to three results per input transaction
// and hands them out one per cycle unless the receiver stalls. Depends on vse_pkg.
module vse_outq import vse_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_batch_t batch_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output result_t       head_o
);

  result_t    entries_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] count_q;
  logic [1:0] push_n;
  logic       pop;

  // Room for a full batch once at most one result is waiting
  assign room_o      = (count_q <= 3'd1);
  assign out_valid_o = (count_q != 3'd0);
  assign head_o      = entries_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign push_n      = push_i ? batch_i.count : 2'd0;

  // Entry storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (push_i && (2'(k) < batch_i.count)) begin
        entries_q[wr_q + 2'(k)] <= batch_i.item[k];
      end
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_n;
      rd_q    <= rd_q + 2'(pop);
      count_q <= count_q + 3'(push_n) - 3'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result queue overrun");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> (count_q + 3'(push_n) <= 3'd4))
    else $error("batch pushed without room");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

>>> rtl/core/voxel_span_expander_unit.sv
`timescale 1ns / 1ps
// The results of a byte enter the result queue when the byte is accepted and leave it
// in order. Throughput: one byte per cycle while the receiver takes results; a byte
// causing two or three results holds the input while the result queue drains.
// Reset clears parser state, offsets and the result queue; column_height and
// column_total return to 1. No clearing pass is needed.
// Depends on vse_pkg, vse_core and vse_outq.
module voxel_span_expander_unit import vse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // byte stream in
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_byte_i,
  // results out
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic [7:0]            data_byte_o,
  output logic                  column_empty_o,
  output logic [OFS_W-1:0]      span_first_o,
  output logic [OFS_W-1:0]      span_final_o,
  output logic                  section_done_o,
  output logic                  overflow_o,
  output logic                  run_last_o
);

  logic          room;
  logic          accept;
  result_batch_t batch;
  result_t       head;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  vse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .batch_o     (batch)
  );

  vse_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .batch_i     (batch),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // Result fields
  assign kind_o         = head.kind;
  assign data_byte_o    = head.data_byte;
  assign column_empty_o = head.column_empty;
  assign span_first_o   = head.span_first;
  assign span_final_o   = head.span_final;
  assign section_done_o = head.section_done;
  assign overflow_o     = head.overflow;
  assign run_last_o     = head.run_last;

endmodule

>>> tb/sv/vse_span_checker.sv
`timescale 1ns / 1ps
// Scoreboard for voxel_span_expander_unit: follows register writes and the byte
// stream, predicts every result transaction and compares it field by field.
// Depends on vse_pkg.
module vse_span_checker import vse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  kind_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  column_empty_i,
  input  logic [OFS_W-1:0]      span_first_i,
  input  logic [OFS_W-1:0]      span_final_i,
  input  logic                  section_done_i,
  input  logic                  overflow_i,
  input  logic                  run_last_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  // shadow registers
  logic [7:0]       height_reg;
  logic [15:0]      total_reg;

  // parser and offset state
  phase_e           parse_ph;
  logic [HPOS_W-1:0] hpos;
  logic [7:0]       pairs_left;
  logic [7:0]       span_len;
  logic [OFS_W-1:0] next_ofs;
  logic [OFS_W-1:0] col_start;
  logic [15:0]      cols_seen;
  logic             ovf_flag;
  logic             col_written;

  // results of the byte being predicted, then the queue of expected ones
  result_t          step_res [3];
  int unsigned      step_n;
  result_t          expected_q [$];
  int unsigned      fail_cnt = 0;

  task automatic add_result(input logic kind, input logic [7:0] data, input logic empty,
                            input logic [OFS_W-1:0] first, input logic [OFS_W-1:0] last,
                            input logic done);
    result_t r;
    r              = '0;
    r.kind         = kind;
    r.data_byte    = data;
    r.column_empty = empty;
    r.span_first   = first;
    r.span_final   = last;
    r.section_done = done;
    r.overflow     = ovf_flag;
    step_res[step_n] = r;
    step_n++;
  endtask

  // every re-emitted byte advances the offset, saturating at the limit
  task automatic emit_byte(input logic [7:0] b);
    if (next_ofs >= OFS_LIMIT) begin
      next_ofs = OFS_LIMIT;
      ovf_flag = 1'b1;
    end else begin
      next_ofs = next_ofs + OFS_W'(1);
    end
    col_written = 1'b1;
    add_result(KIND_DATA, b, 1'b0, '0, '0, 1'b0);
  endtask

  // column record; the last column of a section clears the offsets
  task automatic close_column();
    logic [OFS_W-1:0] first;
    logic [OFS_W-1:0] last;
    logic             done;
    first = '0;
    last  = '0;
    if (col_written) begin
      first = col_start;
      last  = ovf_flag ? OFS_LIMIT : next_ofs - OFS_W'(1);
    end
    cols_seen = cols_seen + 16'd1;
    done      = (cols_seen == total_reg);
    add_result(KIND_RECORD, 8'd0, !col_written, first, last, done);
    hpos        = '0;
    pairs_left  = '0;
    parse_ph    = PH_SKIP;
    col_written = 1'b0;
    if (done) begin
      next_ofs  = '0;
      cols_seen = '0;
      ovf_flag  = 1'b0;
    end
    col_start = next_ofs;
  endtask

  // trailing count, then the column ends once the height is filled
  task automatic close_span();
    emit_byte(span_len);
    parse_ph = PH_SKIP;
    if (hpos >= HPOS_W'(height_reg)) close_column();
  endtask

  task automatic predict_byte(input logic [7:0] b);
    step_n = 0;
    case (parse_ph)
      PH_SKIP: begin
        if (b == height_reg) begin
          close_column();
        end else begin
          emit_byte(b);
          hpos     = hpos + HPOS_W'(b);
          parse_ph = PH_COUNT;
        end
      end
      PH_COUNT: begin
        emit_byte(b);
        span_len   = b;
        pairs_left = b;
        if (b == 8'd0) close_span();
        else parse_ph = PH_COLOR;
      end
      PH_COLOR: begin
        emit_byte(b);
        parse_ph = PH_NORMAL;
      end
      default: begin
        emit_byte(b);
        pairs_left = pairs_left - 8'd1;
        hpos       = hpos + HPOS_W'(1);
        if (pairs_left == 8'd0) close_span();
        else parse_ph = PH_COLOR;
      end
    endcase
    step_res[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_q.push_back(step_res[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (expected_q.size() == 0) begin
      $error("result transaction with nothing expected");
      fail_cnt++;
    end else begin
      want = expected_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(kind_i));
      check_field("data_byte", 32'(want.data_byte), 32'(data_byte_i));
      check_field("column_empty", 32'(want.column_empty), 32'(column_empty_i));
      check_field("span_first", 32'(want.span_first), 32'(span_first_i));
      check_field("span_final", 32'(want.span_final), 32'(span_final_i));
      check_field("section_done", 32'(want.section_done), 32'(section_done_i));
      check_field("overflow", 32'(want.overflow), 32'(overflow_i));
      check_field("run_last", 32'(want.run_last), 32'(run_last_i));
    end
  endtask

  // results leave before the byte that is accepted at the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_reg  = 8'd1;
      total_reg   = 16'd1;
      parse_ph    = PH_SKIP;
      hpos        = '0;
      pairs_left  = '0;
      span_len    = '0;
      next_ofs    = '0;
      col_start   = '0;
      cols_seen   = '0;
      ovf_flag    = 1'b0;
      col_written = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMN_HEIGHT: height_reg = cfg_wdata_i[7:0];
          CFG_COLUMN_TOTAL:  total_reg  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) predict_byte(in_byte_i);
    end
    pending_o    <= expected_q.size();
    fail_count_o <= fail_cnt;
  end

endmodule

>>> tb/sv/tb_voxel_span_expander_unit.sv
`timescale 1ns / 1ps
// Testbench top for voxel_span_expander_unit: clock, reset, stimulus and verdict.
// Depends on vse_pkg, voxel_span_expander_unit and vse_span_checker.
module tb_voxel_span_expander_unit;
  import vse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned PHASE_ITEMS = 20;
  // register indexes the unit does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // height 1, total 1: empty column, two-byte span, three results on one byte
  localparam logic [7:0] DIR_DEFAULT [8] = '{8'd1, 8'd0, 8'd0, 8'd1, 8'd3, 8'd1, 8'd255,
                                             8'd0};
  // height 0, total 3: zero skip ends a column, any span ends it, section end
  localparam logic [7:0] DIR_FLAT [9] = '{8'd0, 8'd5, 8'd0, 8'd255, 8'd2, 8'd170, 8'd85,
                                          8'd0, 8'd255};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic [7:0]            in_byte_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  kind_o;
  logic [7:0]            data_byte_o;
  logic                  column_empty_o;
  logic [OFS_W-1:0]      span_first_o;
  logic [OFS_W-1:0]      span_final_o;
  logic                  section_done_o;
  logic                  overflow_o;
  logic                  run_last_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_cnt       = 0;
  int unsigned sent            = 0;
  logic [7:0]  cur_height      = 8'd1;
  logic        idle_en         = 1'b1;
  logic [1:0]  stall_left      = '0;

  always #4 clk_i = ~clk_i;

  voxel_span_expander_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_byte_i,
    .out_valid_o, .out_stall_i, .kind_o, .data_byte_o, .column_empty_o,
    .span_first_o, .span_final_o, .section_done_o, .overflow_o, .run_last_o
  );

  vse_span_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o), .data_byte_i(data_byte_o),
    .column_empty_i(column_empty_o), .span_first_i(span_first_o),
    .span_final_i(span_final_o), .section_done_i(section_done_o),
    .overflow_i(overflow_o), .run_last_i(run_last_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  // receiver stalls in random bursts; a new burst starts only while idle_en is set
  always @(posedge clk_i) begin
    if (stall_left != 2'd0) begin
      stall_left  <= stall_left - 2'd1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left  <= 2'($urandom_range(0, 2));
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // cycle count for the watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("** voxel_span_expander_unit: FAILED **");
    $finish;
  end

  // one byte transaction, optionally after an idle burst; valid stays high on return
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // drop valid and wait until every expected result has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper byte of the height write is junk the unit must drop
  task automatic load_geometry(input logic [7:0] height, input logic [15:0] total);
    cfg_write(CFG_COLUMN_HEIGHT, {8'($urandom), height});
    cfg_write(CFG_COLUMN_TOTAL, total);
    cur_height = height;
  endtask

  // well-formed column: a few short spans, then the end marker if still short
  task automatic send_column();
    int unsigned spans;
    int unsigned hp;
    int unsigned cnt;
    logic [7:0]  skip;
    bit          ended;
    hp    = 0;
    ended = 0;
    spans = $urandom_range(0, 2);
    for (int s = 0; s < spans && !ended; s++) begin
      skip = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      if (skip == cur_height) skip = skip + 8'd1;
      send_byte(skip);
      cnt = $urandom_range(0, 3);
      send_byte(8'(cnt));
      repeat (cnt) begin
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end
      hp += skip + cnt;
      if (hp >= cur_height) ended = 1;
    end
    if (!ended) send_byte(cur_height);
  endtask

  initial begin : stimulus
    int unsigned target;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset geometry
    foreach (DIR_DEFAULT[i]) send_byte(DIR_DEFAULT[i]);
    drain();

    // directed: zero height, spare indexes written with junk
    load_geometry(8'd0, 16'd3);
    cfg_write(CFG_SPARE_LO, 16'($urandom));
    cfg_write(CFG_SPARE_HI, 16'($urandom));
    foreach (DIR_FLAT[i]) send_byte(DIR_FLAT[i]);
    drain();

    // random columns mixed with noise under several geometries; the last one runs
    // without idling
    for (int p = 0; p < 4; p++) begin
      idle_en <= (p != 3) && ($urandom_range(0, 3) != 0);
      case (p)
        0:       load_geometry(8'd1, 16'($urandom_range(2, 8)));
        1:       load_geometry(8'd255, 16'd1);
        2:       load_geometry(8'($urandom_range(2, 254)), 16'd65025);
        default: load_geometry(8'd0, 16'($urandom_range(2, 8)));
      endcase
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom));
        else send_column();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** voxel_span_expander_unit: PASSED **");
    end else begin
      $display("** voxel_span_expander_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> voxel_span_expander_unit.f
rtl/core/vse_pkg.sv
rtl/core/vse_core.sv
rtl/core/vse_outq.sv
rtl/core/voxel_span_expander_unit.sv
tb/sv/vse_span_checker.sv
tb/sv/tb_voxel_span_expander_unit.sv
